@@ rtl/dmc_pkg.sv @@
`timescale 1ns / 1ps

package dmc_pkg;

  // default geometry
  localparam int INDEX_BITS_DEF       = 6;
  localparam int FILL_EXTRA_WORDS_DEF = 3;
  localparam int ADDR_BITS_DEF        = 16;
  localparam int DATA_BITS_DEF        = 32;

  // width of the position within a run of entries
  localparam int OFS_W = 4;

  // tag value of every entry after reset (masked to the tag width)
  localparam int TAG_RESET = 60;

  // controller phases
  typedef enum logic [3:0] {
    PH_START_A,
    PH_START_B,
    PH_IDLE,
    PH_WRITE_DONE,
    PH_READ_DONE,
    PH_FILL,
    PH_FILL_NEXT,
    PH_FILL_PAUSE,
    PH_WB,
    PH_WB_WAIT_A,
    PH_WB_WAIT_B
  } phase_t;

  // control of one tag store write
  typedef struct packed {
    logic en;
    logic empty;
  } tag_wr_ctl_t;

endpackage

@@ rtl/dmc_tag_store.sv @@
`timescale 1ns / 1ps

module dmc_tag_store #(
  parameter int INDEX_BITS = dmc_pkg::INDEX_BITS_DEF,
  parameter int TAG_W      = dmc_pkg::ADDR_BITS_DEF - dmc_pkg::INDEX_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  output logic                    busy,
  input  logic                    rd_en,
  input  logic [INDEX_BITS-1:0]   ridx,
  input  logic [INDEX_BITS-1:0]   rrun,
  output logic [TAG_W-1:0]        tag_idx,
  output logic                    empty_idx,
  output logic [TAG_W-1:0]        tag_run,
  input  dmc_pkg::tag_wr_ctl_t    wr,
  input  logic [INDEX_BITS-1:0]   waddr,
  input  logic [TAG_W-1:0]        wtag
);

  localparam int ENTRIES = 1 << INDEX_BITS;
  localparam logic [TAG_W-1:0] RST_TAG = TAG_W'(dmc_pkg::TAG_RESET);
  localparam logic [INDEX_BITS-1:0] LAST_ENTRY = INDEX_BITS'(ENTRIES - 1);

  // entry word: {empty, tag}
  logic [TAG_W:0] tag_mem [ENTRIES];

  logic                  busy_r;
  logic [INDEX_BITS-1:0] clr_cnt_r;
  logic [TAG_W:0]        q_idx_r, q_run_r, fwd_word_r;
  logic                  fwd_idx_r, fwd_run_r;
  logic [TAG_W:0]        word_idx, word_run;

  // clearing sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_ENTRY) begin
        busy_r <= 1'b0;
      end
    end
  end

  // single write port
  always_ff @(posedge clk) begin
    if (busy_r) begin
      tag_mem[clr_cnt_r] <= {1'b1, RST_TAG};
    end else if (wr.en) begin
      tag_mem[waddr] <= {wr.empty, wtag};
    end
  end

  // two registered read ports, with bypass of a write at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_idx_r    <= tag_mem[ridx];
      q_run_r    <= tag_mem[rrun];
      fwd_idx_r  <= wr.en && (waddr == ridx);
      fwd_run_r  <= wr.en && (waddr == rrun);
      fwd_word_r <= {wr.empty, wtag};
    end
  end

  assign word_idx  = fwd_idx_r ? fwd_word_r : q_idx_r;
  assign word_run  = fwd_run_r ? fwd_word_r : q_run_r;
  assign tag_idx   = word_idx[TAG_W-1:0];
  assign empty_idx = word_idx[TAG_W];
  assign tag_run   = word_run[TAG_W-1:0];
  assign busy      = busy_r;

endmodule

@@ rtl/direct_mapped_cache_controller.sv @@
`timescale 1ns / 1ps

// channel   direction  ports                                         transfer when
// in_*      input      write/read request, address, data, ram ack    in_valid & !in_stall
// out_*     output     cpu ack/data, ram enables, address, data      out_valid & !out_stall
//
// one item per cycle unless in_stall is high: each item is one controller clock,
// registered at the input, then processed in one pass into the result register
// after reset the tag store is swept over all 2**INDEX_BITS entries, with in_stall high
// reset is synchronous, active low; stored data is undefined until written
// in_stall is high in the sweep, or while both registers are full and out_stall is high

module direct_mapped_cache_controller #(
  parameter int INDEX_BITS       = dmc_pkg::INDEX_BITS_DEF,
  parameter int FILL_EXTRA_WORDS = dmc_pkg::FILL_EXTRA_WORDS_DEF,
  parameter int ADDR_BITS        = dmc_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS        = dmc_pkg::DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_write_request,
  input  logic                 in_read_request,
  input  logic [ADDR_BITS-1:0] in_cpu_address,
  input  logic [DATA_BITS-1:0] in_cpu_write_data,
  input  logic                 in_backing_ack,
  input  logic [DATA_BITS-1:0] in_backing_read_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_cpu_ack,
  output logic [DATA_BITS-1:0] out_cpu_read_data,
  output logic                 out_backing_write_enable,
  output logic                 out_backing_read_enable,
  output logic [ADDR_BITS-1:0] out_backing_address,
  output logic [DATA_BITS-1:0] out_backing_write_data
);

  localparam int ENTRIES = 1 << INDEX_BITS;
  localparam int TAG_W   = ADDR_BITS - INDEX_BITS;
  localparam int OFS_W   = dmc_pkg::OFS_W;
  localparam logic [OFS_W-1:0] LAST_OFS = OFS_W'(FILL_EXTRA_WORDS);

  // input register
  logic                 in_v_r;
  logic                 wr_q_r, rd_q_r, ack_q_r;
  logic [ADDR_BITS-1:0] addr_q_r;
  logic [DATA_BITS-1:0] wdata_q_r, bdata_q_r;

  // controller state
  dmc_pkg::phase_t phase_r, phase_nxt;
  logic [OFS_W-1:0] wo_r, wo_nxt;
  logic             hw_r, hw_nxt, hr_r, hr_nxt;

  // result register
  logic                 out_v_r;
  logic                 ack_r, we_r, re_r;
  logic [ADDR_BITS-1:0] baddr_r;
  logic [DATA_BITS-1:0] rdata_r;

  // handshake
  logic busy, out_free, adv, accept;

  // tag store
  logic [TAG_W-1:0]       tag_idx, tag_run, tag_wtag;
  logic                   empty_idx;
  logic [INDEX_BITS-1:0]  tag_waddr, rd_idx, rd_run;
  dmc_pkg::tag_wr_ctl_t   tag_wr;

  // data memory
  logic [DATA_BITS-1:0]  data_mem [ENTRIES];
  logic                  dat_we;
  logic [INDEX_BITS-1:0] dat_waddr, dat_raddr;
  logic [DATA_BITS-1:0]  dat_wdata;

  // per item decode
  logic [INDEX_BITS-1:0] idx, run;
  logic [TAG_W-1:0]      tag;
  logic [ADDR_BITS-1:0]  fill_addr;
  logic                  o_ack, o_we, o_re;
  logic [ADDR_BITS-1:0]  o_addr;

  // flow control
  assign out_free = !out_v_r || !out_stall;
  assign adv      = in_v_r && out_free;
  assign in_stall = busy || (in_v_r && !out_free);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= accept || (in_v_r && !adv);
      out_v_r <= adv || (out_v_r && out_stall);
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_q_r    <= in_write_request;
      rd_q_r    <= in_read_request;
      addr_q_r  <= in_cpu_address;
      wdata_q_r <= in_cpu_write_data;
      ack_q_r   <= in_backing_ack;
      bdata_q_r <= in_backing_read_data;
    end
  end

  // tag store read for the incoming item uses the state it will see
  assign rd_idx = in_cpu_address[INDEX_BITS-1:0];
  assign rd_run = rd_idx + INDEX_BITS'(wo_nxt);

  dmc_tag_store #(
    .INDEX_BITS (INDEX_BITS),
    .TAG_W      (TAG_W)
  ) u_tag_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .rd_en     (accept),
    .ridx      (rd_idx),
    .rrun      (rd_run),
    .tag_idx   (tag_idx),
    .empty_idx (empty_idx),
    .tag_run   (tag_run),
    .wr        (tag_wr),
    .waddr     (tag_waddr),
    .wtag      (tag_wtag)
  );

  // address fields of the current item
  assign idx       = addr_q_r[INDEX_BITS-1:0];
  assign tag       = addr_q_r[ADDR_BITS-1:INDEX_BITS];
  assign run       = idx + INDEX_BITS'(wo_r);
  assign fill_addr = addr_q_r + ADDR_BITS'(wo_r);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dmc_pkg::PH_START_A;
      wo_r    <= '0;
      hw_r    <= 1'b0;
      hr_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wo_r    <= wo_nxt;
      hw_r    <= hw_nxt;
      hr_r    <= hr_nxt;
    end
  end

  // cycle outputs, next state and store writes
  always_comb begin
    phase_nxt    = phase_r;
    wo_nxt       = wo_r;
    hw_nxt       = hw_r;
    hr_nxt       = hr_r;
    tag_wr.en    = 1'b0;
    tag_wr.empty = 1'b0;
    tag_waddr    = run;
    tag_wtag     = fill_addr[ADDR_BITS-1:INDEX_BITS];
    dat_we       = 1'b0;
    dat_waddr    = run;
    dat_wdata    = bdata_q_r;
    dat_raddr    = idx;
    o_ack        = 1'b0;
    o_we         = 1'b0;
    o_re         = 1'b0;
    o_addr       = addr_q_r;

    case (phase_r)
      dmc_pkg::PH_WRITE_DONE, dmc_pkg::PH_READ_DONE: begin
        o_ack = 1'b1;
      end
      dmc_pkg::PH_FILL, dmc_pkg::PH_FILL_PAUSE: begin
        o_re   = 1'b1;
        o_addr = fill_addr;
      end
      dmc_pkg::PH_WB: begin
        o_we      = 1'b1;
        o_addr    = {tag_run, run};
        dat_raddr = run;
      end
      default: begin
      end
    endcase

    if (adv) begin
      case (phase_r)
        dmc_pkg::PH_START_A: begin
          phase_nxt = dmc_pkg::PH_START_B;
        end
        dmc_pkg::PH_IDLE: begin
          wo_nxt = '0;
          hw_nxt = wr_q_r;
          hr_nxt = rd_q_r;
          if (wr_q_r != rd_q_r) begin
            if (empty_idx) begin
              phase_nxt = dmc_pkg::PH_FILL;
            end else if (tag != tag_idx) begin
              phase_nxt = dmc_pkg::PH_WB;
            end else if (wr_q_r) begin
              phase_nxt = dmc_pkg::PH_WRITE_DONE;
            end else begin
              phase_nxt = dmc_pkg::PH_READ_DONE;
            end
          end
        end
        dmc_pkg::PH_WRITE_DONE: begin
          tag_wr.en = 1'b1;
          tag_waddr = idx;
          tag_wtag  = tag;
          dat_we    = 1'b1;
          dat_waddr = idx;
          dat_wdata = wdata_q_r;
          phase_nxt = dmc_pkg::PH_IDLE;
        end
        dmc_pkg::PH_FILL: begin
          if (ack_q_r) begin
            tag_wr.en = 1'b1;
            dat_we    = 1'b1;
            if (wo_r < LAST_OFS) begin
              phase_nxt = dmc_pkg::PH_FILL_NEXT;
            end else begin
              wo_nxt    = '0;
              phase_nxt = (hw_r && !hr_r) ? dmc_pkg::PH_WRITE_DONE
                                          : dmc_pkg::PH_READ_DONE;
            end
          end
        end
        dmc_pkg::PH_FILL_NEXT: begin
          wo_nxt    = wo_r + 1'b1;
          phase_nxt = dmc_pkg::PH_FILL;
        end
        dmc_pkg::PH_FILL_PAUSE: begin
          phase_nxt = dmc_pkg::PH_FILL;
        end
        dmc_pkg::PH_WB: begin
          if (ack_q_r) begin
            // mark empty, keep the tag
            tag_wr.en    = 1'b1;
            tag_wr.empty = 1'b1;
            tag_wtag     = tag_run;
            if (wo_r < LAST_OFS) begin
              phase_nxt = dmc_pkg::PH_WB_WAIT_A;
            end else begin
              wo_nxt    = '0;
              phase_nxt = dmc_pkg::PH_FILL_PAUSE;
            end
          end
        end
        dmc_pkg::PH_WB_WAIT_A: begin
          phase_nxt = dmc_pkg::PH_WB_WAIT_B;
        end
        dmc_pkg::PH_WB_WAIT_B: begin
          wo_nxt    = wo_r + 1'b1;
          phase_nxt = dmc_pkg::PH_WB;
        end
        default: begin
          phase_nxt = dmc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // data memory, read before write at the same edge
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= data_mem[dat_raddr];
      if (dat_we) begin
        data_mem[dat_waddr] <= dat_wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      ack_r   <= o_ack;
      we_r    <= o_we;
      re_r    <= o_re;
      baddr_r <= o_addr;
    end
  end

  assign out_valid                = out_v_r;
  assign out_cpu_ack              = ack_r;
  assign out_cpu_read_data        = ack_r ? rdata_r : '0;
  assign out_backing_write_enable = we_r;
  assign out_backing_read_enable  = re_r;
  assign out_backing_address      = baddr_r;
  assign out_backing_write_data   = we_r ? rdata_r : '0;

  // at most one kind of activity in a result
  a_one_activity: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $onehot0({ack_r, we_r, re_r}))
    else $error("cpu ack and ram enables overlap");

  // position within a run never passes the last word
  a_ofs_range: assert property (@(posedge clk) disable iff (!rst_n)
    wo_r <= LAST_OFS)
    else $error("word offset beyond run length");

  // a completed write returns to idle
  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (phase_r == dmc_pkg::PH_WRITE_DONE) |=> phase_r == dmc_pkg::PH_IDLE)
    else $error("write completion did not return to idle");

  // no item is held while the tag store is still being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_v_r && !out_v_r)
    else $error("item present during tag clearing");

endmodule
